// File: src/quaternion_from_angular_rate_unit_assert.svh
// Assertion macros shared by the quaternion-from-rate RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef QUATERNION_FROM_ANGULAR_RATE_UNIT_ASSERT_SVH
`define QUATERNION_FROM_ANGULAR_RATE_UNIT_ASSERT_SVH

// pre holds in a cycle -> post holds in the same cycle
`define QFAR_ASSERT_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("qfar: same-cycle check failed");

// pre holds in a cycle -> post holds in the next cycle
`define QFAR_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("qfar: next-cycle check failed");

`endif

// File: src/qfar_pkg.sv
// ----------------------------------------------------------------------------
// qfar_pkg
// Types and constants of the quaternion-from-angular-rate pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qfar_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    localparam logic [31:0] PERIOD_RESET = 32'd4294967;
    localparam logic [63:0] SMALL_LIMIT  = 64'd720575940;
    localparam logic [24:0] INV_PI_Q26   = 25'd21361415;

    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

    localparam logic        [32:0] ONE_MAG = 33'd1073741824;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam logic        [31:0] SMALL_DEN = 32'd134217728;

    // arctangent of 2^-i in 2^-32 turns
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef logic signed [31:0] t_rate;
    typedef logic signed [31:0] t_quat;
    typedef logic        [31:0] t_period;

    typedef struct packed {
        logic [2:0]       neg;
        logic [2:0][31:0] absv;
    } t_rate_side;

    typedef struct packed {
        logic             small_ang;
        logic             rot_neg;
        logic [2:0]       neg;
        logic [2:0][31:0] absv;
        logic [2:0][63:0] sp;
        logic [31:0]      mag;
    } t_rot_side;

    typedef struct packed {
        logic        small_ang;
        logic [3:0]  sgn;
        logic [32:0] wmag;
    } t_vec_side;

    typedef struct packed {
        logic             small_ang;
        logic [3:0]       sgn;
        logic [3:0][32:0] mag;
    } t_norm_side;

    typedef struct packed {
        logic             small_ang;
        logic             nzero;
        logic [3:0]       sgn;
        logic [3:0][32:0] mag;
    } t_scale_side;

endpackage

`default_nettype wire

// File: src/qfar_if.sv
// ----------------------------------------------------------------------------
// qfar_if
// Valid/ready channels of the quaternion-from-angular-rate unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface qfar_cfg_if;
    import qfar_pkg::*;
    logic    valid;
    logic    ready;
    t_period sample_period;
    modport source (output valid, output sample_period, input ready);
    modport sink   (input valid, input sample_period, output ready);
endinterface

interface qfar_in_if;
    import qfar_pkg::*;
    logic  valid;
    logic  ready;
    t_rate omega_x;
    t_rate omega_y;
    t_rate omega_z;
    modport source (output valid, output omega_x, output omega_y, output omega_z,
                    input ready);
    modport sink   (input valid, input omega_x, input omega_y, input omega_z,
                    output ready);
endinterface

interface qfar_out_if;
    import qfar_pkg::*;
    logic  valid;
    logic  ready;
    t_quat q_w;
    t_quat q_x;
    t_quat q_y;
    t_quat q_z;
    logic  small_angle;
    modport source (output valid, output q_w, output q_x, output q_y, output q_z,
                    output small_angle, input ready);
    modport sink   (input valid, input q_w, input q_x, input q_y, input q_z,
                    input small_angle, output ready);
endinterface

`default_nettype wire

// File: src/quaternion_from_angular_rate_unit.sv
// ----------------------------------------------------------------------------
// quaternion_from_angular_rate_unit
// Delta rotation quaternion (Q1.30) from one gyro rate sample and the
// configured sample period, normalized and saturated to +-1.
// ----------------------------------------------------------------------------
//   channel   dir   payload                              beat when
//   i_cfg     in    sample_period (Q0.32 s)              valid && ready
//   i_in      in    omega_x/y/z (Q7.24 rad/s)            valid && ready
//   o_out     out   q_w/x/y/z (Q1.30), small_angle       valid && ready
//
// One beat enters per cycle while the output register is empty or taken; the path
// runs through two 32-stage square roots, two 32-stage dividers and the CORDIC rotator.
// All stages advance together whenever the output register is empty or taken.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and loads the default sample period.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_from_angular_rate_unit #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qfar_cfg_if.sink    i_cfg,
    qfar_in_if.sink     i_in,
    qfar_out_if.source  o_out
);
    import qfar_pkg::*;

    logic    en;
    t_period r_sample_period;

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= PERIOD_RESET;
        end else if (i_cfg.valid) begin
            r_sample_period <= i_cfg.sample_period;
        end
    end

    // ---------------- stage registers ----------------
    logic             r_out_vld;
    assign en          = !r_out_vld || o_out.ready;
    assign i_in.ready  = en;

    logic             r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld;
    logic             r8_vld, r9_vld, r10_vld, r11_vld, r12_vld;
    t_rate_side       r1_rate, r2_rate, r3_rate, r4_rate, r5_rate, r6_rate;
    logic [2:0][63:0] r2_sq;
    logic [63:0]      r3_sum;
    logic [63:0]      r4_angle;
    logic [2:0][63:0] r4_sp, r5_sp, r6_sp;
    logic [31:0]      r4_mag, r5_mag, r6_mag;
    logic             r5_small, r6_small;
    logic [44:0]      r5_p0;
    logic [43:0]      r5_p1;
    logic [31:0]      r6_phase;
    logic signed [33:0] r7_z;
    t_rot_side        r7_side;
    logic signed [33:0] r8_x;
    logic             r8_ysgn;
    logic [2:0][63:0] r8_prod;
    t_rot_side        r8_side;
    logic [2:0][63:0] r9_num;
    logic [31:0]      r9_den;
    t_vec_side        r9_vec;
    logic [3:0][63:0] r10_sq;
    t_norm_side       r10_norm, r11_norm;
    logic [63:0]      r11_sum;
    logic [3:0][63:0] r12_num;
    logic [31:0]      r12_den;
    t_scale_side      r12_scale;
    t_quat [3:0]      r_out_q;
    logic             r_out_small;

    // ---------------- stage 1: magnitudes ----------------
    t_rate_side n1_rate;
    always_comb begin
        n1_rate.neg  = {i_in.omega_z[31], i_in.omega_y[31], i_in.omega_x[31]};
        n1_rate.absv[0] = i_in.omega_x[31] ? (~i_in.omega_x + 32'd1) : i_in.omega_x;
        n1_rate.absv[1] = i_in.omega_y[31] ? (~i_in.omega_y + 32'd1) : i_in.omega_y;
        n1_rate.absv[2] = i_in.omega_z[31] ? (~i_in.omega_z + 32'd1) : i_in.omega_z;
    end

    // ---------------- rate magnitude root ----------------
    logic        sa_vld;
    logic [31:0] sa_mag;
    t_rate_side  sa_side;

    qfar_isqrt #(.SIDE_W($bits(t_rate_side))) u_rate_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r3_vld),
        .i_val   (r3_sum),
        .i_side  (r3_rate),
        .o_vld   (sa_vld),
        .o_root  (sa_mag),
        .o_side  (sa_side)
    );

    // ---------------- stage 7: fold phase into +-1/4 turn ----------------
    logic signed [33:0] phase_s;
    logic signed [33:0] n7_z;
    logic               n7_neg;
    always_comb begin
        phase_s = {{2{r6_phase[31]}}, r6_phase};
        priority if (phase_s > QUARTER_TURN) begin
            n7_z   = phase_s - HALF_TURN;
            n7_neg = 1'b1;
        end else if (phase_s < -QUARTER_TURN) begin
            n7_z   = phase_s + HALF_TURN;
            n7_neg = 1'b1;
        end else begin
            n7_z   = phase_s;
            n7_neg = 1'b0;
        end
    end

    // ---------------- CORDIC rotator ----------------
    logic               r_c_vld  [CORDIC_STAGES];
    logic signed [33:0] r_c_x    [CORDIC_STAGES];
    logic signed [33:0] r_c_y    [CORDIC_STAGES];
    logic signed [33:0] r_c_z    [CORDIC_STAGES];
    t_rot_side          r_c_side [CORDIC_STAGES];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        logic               vld_in;
        logic signed [33:0] x_in, y_in, z_in, atan_k;
        t_rot_side          side_in;

        if (k == 0) begin : g_first
            assign vld_in  = r7_vld;
            assign x_in    = CORDIC_GAIN;
            assign y_in    = '0;
            assign z_in    = r7_z;
            assign side_in = r7_side;
        end else begin : g_next
            assign vld_in  = r_c_vld[k-1];
            assign x_in    = r_c_x[k-1];
            assign y_in    = r_c_y[k-1];
            assign z_in    = r_c_z[k-1];
            assign side_in = r_c_side[k-1];
        end

        assign atan_k = {2'b00, ATAN_TURNS[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_vld[k] <= 1'b0;
            end else if (en) begin
                r_c_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_c_side[k] <= side_in;
                if (!z_in[33]) begin
                    r_c_x[k] <= x_in - (y_in >>> k);
                    r_c_y[k] <= y_in + (x_in >>> k);
                    r_c_z[k] <= z_in - atan_k;
                end else begin
                    r_c_x[k] <= x_in + (y_in >>> k);
                    r_c_y[k] <= y_in - (x_in >>> k);
                    r_c_z[k] <= z_in + atan_k;
                end
            end
        end
    end

    // ---------------- stage 8: undo fold, scale axis ----------------
    logic               c_vld;
    logic signed [33:0] c_x, c_y;
    t_rot_side          c_side;
    logic signed [33:0] n8_x;
    logic [31:0]        y_abs;
    logic [2:0][63:0]   n8_prod;
    assign c_vld  = r_c_vld[CORDIC_STAGES-1];
    assign c_x    = r_c_x[CORDIC_STAGES-1];
    assign c_y    = r_c_y[CORDIC_STAGES-1];
    assign c_side = r_c_side[CORDIC_STAGES-1];

    always_comb begin
        n8_x  = c_side.rot_neg ? -c_x : c_x;
        y_abs = c_y[33] ? 32'(-c_y) : c_y[31:0];
        for (int i = 0; i < 3; i++) begin
            n8_prod[i] = 64'(c_side.absv[i]) * 64'(y_abs);
        end
    end

    // ---------------- stage 9: pick branch, add rounding ----------------
    logic [2:0][63:0] n9_num;
    logic [31:0]      n9_den;
    t_vec_side        n9_vec;
    logic signed [33:0] x_abs;
    always_comb begin
        x_abs        = r8_x[33] ? -r8_x : r8_x;
        n9_den       = r8_side.small_ang ? SMALL_DEN : r8_side.mag;
        n9_vec.small_ang = r8_side.small_ang;
        n9_vec.wmag  = r8_side.small_ang ? ONE_MAG : x_abs[32:0];
        n9_vec.sgn[0] = r8_side.small_ang ? 1'b0 : r8_x[33];
        for (int i = 0; i < 3; i++) begin
            n9_num[i] = (r8_side.small_ang ? r8_side.sp[i] : r8_prod[i])
                      + {33'd0, n9_den[31:1]};
            n9_vec.sgn[i+1] = r8_side.small_ang ? r8_side.neg[i]
                                                : (r8_side.neg[i] ^ r8_ysgn);
        end
    end

    logic             da_vld;
    logic [2:0][31:0] da_quo;
    t_vec_side        da_side;

    qfar_div #(.LANES(3), .SIDE_W($bits(t_vec_side))) u_axis_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r9_vld),
        .i_num   (r9_num),
        .i_den   (r9_den),
        .i_side  (r9_vec),
        .o_vld   (da_vld),
        .o_quo   (da_quo),
        .o_side  (da_side)
    );

    // ---------------- stage 10: component squares ----------------
    t_norm_side       n10_norm;
    logic [3:0][63:0] n10_sq;
    always_comb begin
        n10_norm.small_ang = da_side.small_ang;
        n10_norm.sgn    = da_side.sgn;
        n10_norm.mag[0] = da_side.wmag;
        for (int i = 0; i < 3; i++) begin
            n10_norm.mag[i+1] = {1'b0, da_quo[i]};
        end
        for (int i = 0; i < 4; i++) begin
            n10_sq[i] = 64'(n10_norm.mag[i]) * 64'(n10_norm.mag[i]);
        end
    end

    logic        sb_vld;
    logic [31:0] sb_root;
    t_norm_side  sb_side;

    qfar_isqrt #(.SIDE_W($bits(t_norm_side))) u_norm_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r11_vld),
        .i_val   (r11_sum),
        .i_side  (r11_norm),
        .o_vld   (sb_vld),
        .o_root  (sb_root),
        .o_side  (sb_side)
    );

    // ---------------- stage 12: normalize numerators ----------------
    logic [3:0][63:0] n12_num;
    t_scale_side      n12_scale;
    always_comb begin
        n12_scale.small_ang = sb_side.small_ang;
        n12_scale.nzero = (sb_root == 32'd0);
        n12_scale.sgn   = sb_side.sgn;
        n12_scale.mag   = sb_side.mag;
        for (int i = 0; i < 4; i++) begin
            n12_num[i] = {1'b0, sb_side.mag[i], 30'd0} + {33'd0, sb_root[31:1]};
        end
    end

    logic             db_vld;
    logic [3:0][31:0] db_quo;
    t_scale_side      db_side;

    qfar_div #(.LANES(4), .SIDE_W($bits(t_scale_side))) u_norm_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r12_vld),
        .i_num   (r12_num),
        .i_den   (r12_den),
        .i_side  (r12_scale),
        .o_vld   (db_vld),
        .o_quo   (db_quo),
        .o_side  (db_side)
    );

    // ---------------- output: saturate and sign ----------------
    t_quat [3:0] n_out_q;
    always_comb begin
        logic [32:0] m;
        logic [31:0] m32;
        for (int i = 0; i < 4; i++) begin
            m   = db_side.nzero ? db_side.mag[i] : {1'b0, db_quo[i]};
            m32 = (m > ONE_MAG) ? ONE_MAG[31:0] : m[31:0];
            n_out_q[i] = db_side.sgn[i] ? (~m32 + 32'd1) : m32;
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r8_vld    <= 1'b0;
            r9_vld    <= 1'b0;
            r10_vld   <= 1'b0;
            r11_vld   <= 1'b0;
            r12_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_vld    <= i_in.valid;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= sa_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= r6_vld;
            r8_vld    <= c_vld;
            r9_vld    <= r8_vld;
            r10_vld   <= da_vld;
            r11_vld   <= r10_vld;
            r12_vld   <= sb_vld;
            r_out_vld <= db_vld;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_rate <= n1_rate;

            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= 64'(r1_rate.absv[i]) * 64'(r1_rate.absv[i]);
            end
            r2_rate <= r1_rate;

            r3_sum  <= r2_sq[0] + r2_sq[1] + r2_sq[2];
            r3_rate <= r2_rate;

            r4_angle <= 64'(sa_mag) * 64'(r_sample_period);
            for (int i = 0; i < 3; i++) begin
                r4_sp[i] <= 64'(sa_side.absv[i]) * 64'(r_sample_period);
            end
            r4_rate <= sa_side;
            r4_mag  <= sa_mag;

            // half angle is angle >> 25; split it for the 1/pi scaling
            r5_small <= (r4_angle < SMALL_LIMIT);
            r5_p0    <= 45'(r4_angle[44:25]) * 45'(INV_PI_Q26);
            r5_p1    <= 44'(r4_angle[63:45]) * 44'(INV_PI_Q26);
            r5_sp    <= r4_sp;
            r5_rate  <= r4_rate;
            r5_mag   <= r4_mag;

            r6_phase <= 32'(({r5_p1, 20'd0} + 64'(r5_p0)) >> 27);
            r6_small <= r5_small;
            r6_sp    <= r5_sp;
            r6_rate  <= r5_rate;
            r6_mag   <= r5_mag;

            r7_z              <= n7_z;
            r7_side.small_ang <= r6_small;
            r7_side.rot_neg   <= n7_neg;
            r7_side.neg       <= r6_rate.neg;
            r7_side.absv      <= r6_rate.absv;
            r7_side.sp        <= r6_sp;
            r7_side.mag       <= r6_mag;

            r8_x    <= n8_x;
            r8_ysgn <= c_y[33] ^ c_side.rot_neg;
            r8_prod <= n8_prod;
            r8_side <= c_side;

            r9_num <= n9_num;
            r9_den <= n9_den;
            r9_vec <= n9_vec;

            r10_sq   <= n10_sq;
            r10_norm <= n10_norm;

            r11_sum  <= r10_sq[0] + r10_sq[1] + r10_sq[2] + r10_sq[3];
            r11_norm <= r10_norm;

            r12_num   <= n12_num;
            r12_den   <= sb_root;
            r12_scale <= n12_scale;

            r_out_q     <= n_out_q;
            r_out_small <= db_side.small_ang;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.q_w         = r_out_q[0];
    assign o_out.q_x         = r_out_q[1];
    assign o_out.q_y         = r_out_q[2];
    assign o_out.q_z         = r_out_q[3];
    assign o_out.small_angle = r_out_small;

    // ---------------- checks ----------------
`include "quaternion_from_angular_rate_unit_assert.svh"

    `QFAR_ASSERT_IMPLY(a_small_unit_w, r_out_vld && r_out_small, r_out_q[0] == ONE_Q30)
    `QFAR_ASSERT_IMPLY(a_w_bounded, r_out_vld, (r_out_q[0] <= ONE_Q30) && (r_out_q[0] >= -ONE_Q30))
    `QFAR_ASSERT_IMPLY(a_small_tiny_x, r_out_vld && r_out_small, (r_out_q[1] <= 32'sd8) && (r_out_q[1] >= -32'sd8))
    `QFAR_ASSERT_NEXT(a_stall_holds, r_out_vld && !o_out.ready, r_out_vld)

endmodule

`default_nettype wire

// File: src/qfar_isqrt.sv
// ----------------------------------------------------------------------------
// qfar_isqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qfar_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [63:0]       i_val,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [31:0]       o_root,
    output logic [SIDE_W-1:0] o_side
);
    import qfar_pkg::*;

    logic              r_vld  [SQRT_STEPS];
    logic [65:0]       r_rem  [SQRT_STEPS];
    logic [31:0]       r_root [SQRT_STEPS];
    logic [SIDE_W-1:0] r_side [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam int BIT = SQRT_STEPS - 1 - k;
        logic              vld_in;
        logic [65:0]       rem_in;
        logic [31:0]       root_in;
        logic [SIDE_W-1:0] side_in;
        logic [65:0]       trial;
        logic [65:0]       n_rem;
        logic [31:0]       n_root;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rem_in  = {2'b00, i_val};
            assign root_in = 32'd0;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
        end

        // (root + 2^b)^2 - root^2
        assign trial = ({34'd0, root_in} << (BIT + 1)) + (66'd1 << (2 * BIT));

        always_comb begin
            if (rem_in >= trial) begin
                n_rem  = rem_in - trial;
                n_root = root_in | (32'd1 << BIT);
            end else begin
                n_rem  = rem_in;
                n_root = root_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[SQRT_STEPS-1];
    assign o_root = r_root[SQRT_STEPS-1];
    assign o_side = r_side[SQRT_STEPS-1];

endmodule

`default_nettype wire

// File: src/qfar_div.sv
// ----------------------------------------------------------------------------
// qfar_div
// Pipelined restoring divider, several lanes over one shared divisor.
// The quotient must fit 32 bits (upper numerator half below the divisor).
// ----------------------------------------------------------------------------
`default_nettype none

module qfar_div #(
    parameter int LANES  = 3,
    parameter int SIDE_W = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [LANES-1:0][63:0] i_num,
    input  logic [31:0]            i_den,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_vld,
    output logic [LANES-1:0][31:0] o_quo,
    output logic [SIDE_W-1:0]      o_side
);
    import qfar_pkg::*;

    logic                   r_vld  [DIV_STEPS];
    logic [LANES-1:0][63:0] r_num  [DIV_STEPS];
    logic [LANES-1:0][31:0] r_rem  [DIV_STEPS];
    logic [LANES-1:0][31:0] r_quo  [DIV_STEPS];
    logic [31:0]            r_den  [DIV_STEPS];
    logic [SIDE_W-1:0]      r_side [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        localparam int BIT = DIV_STEPS - 1 - k;
        logic                   vld_in;
        logic [LANES-1:0][63:0] num_in;
        logic [LANES-1:0][31:0] rem_in;
        logic [LANES-1:0][31:0] quo_in;
        logic [31:0]            den_in;
        logic [SIDE_W-1:0]      side_in;
        logic [LANES-1:0][31:0] n_rem;
        logic [LANES-1:0][31:0] n_quo;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign num_in  = i_num;
            assign den_in  = i_den;
            assign side_in = i_side;
            assign quo_in  = '0;
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l] = i_num[l][63:32];
                end
            end
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign num_in  = r_num[k-1];
            assign rem_in  = r_rem[k-1];
            assign quo_in  = r_quo[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            logic [32:0] trial;
            for (int l = 0; l < LANES; l++) begin
                trial = {rem_in[l], num_in[l][BIT]};
                if (trial >= {1'b0, den_in}) begin
                    n_rem[l] = 32'(trial - {1'b0, den_in});
                    n_quo[l] = quo_in[l] | (32'd1 << BIT);
                end else begin
                    n_rem[l] = trial[31:0];
                    n_quo[l] = quo_in[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]  <= num_in;
                r_rem[k]  <= n_rem;
                r_quo[k]  <= n_quo;
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[DIV_STEPS-1];
    assign o_quo  = r_quo[DIV_STEPS-1];
    assign o_side = r_side[DIV_STEPS-1];

endmodule

`default_nettype wire

// File: verif/quaternion_from_angular_rate_unit_tb.sv
// ----------------------------------------------------------------------------
// quaternion_from_angular_rate_unit_tb
// Drives gyro rate samples and sample periods into the unit. A local
// fixed-point model predicts each delta quaternion. Every output beat is
// checked field by field against the oldest prediction. Both sides of the
// stream take random gaps, and the period is changed between phases while
// the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_from_angular_rate_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qfar_pkg::*;

    localparam int STAGES     = 24;
    localparam int PIPE_DEPTH = 141 + STAGES;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        t_quat w;
        t_quat x;
        t_quat y;
        t_quat z;
        logic  small_ang;
    } t_quat_beat;

    logic clk = 1'b0;
    logic rst_n;

    qfar_cfg_if cfg_ch();
    qfar_in_if  rate_ch();
    qfar_out_if quat_ch();

    quaternion_from_angular_rate_unit #(.CORDIC_STAGES(STAGES)) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_in    (rate_ch.sink),
        .o_out   (quat_ch.source)
    );

    always #5 clk = ~clk;

    t_quat_beat pending_quats[$];
    t_period    cur_period;
    int         mismatches = 0;
    int         idle_cycles = 0;
    bit         no_gaps;

    // ---------------- prediction ----------------
    function automatic logic [63:0] abs64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic longint div_nearest(input longint s, input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] q;
        q = (num + den / 2) / den;
        return s < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_quat_beat rate_to_quat(input t_rate ox, input t_rate oy,
                                                input t_rate oz, input t_period dt);
        longint      om [3];
        longint      q [4];
        longint      x, y, z, dx, dy, atn, v, sg;
        logic [63:0] sum, mag, angle, half, phase, p, n2, n;
        logic        is_small;
        bit          flip;
        int          i;
        t_quat_beat  res;
        om[0] = ox;
        om[1] = oy;
        om[2] = oz;
        sum = 0;
        for (i = 0; i < 3; i++) sum = sum + abs64(om[i]) * abs64(om[i]);
        mag = root64(sum);
        angle = mag * {32'd0, dt};
        is_small = angle < SMALL_LIMIT;
        if (is_small) begin
            q[0] = 64'sd1073741824;
            for (i = 0; i < 3; i++) begin
                p = abs64(om[i]) * {32'd0, dt};
                v = longint'((p + (64'd1 << 26)) >> 27);
                q[i + 1] = om[i] < 0 ? -v : v;
            end
        end else begin
            half = angle >> 25;
            phase = ((half * 64'd21361415) >> 27) & 64'hFFFF_FFFF;
            z = longint'($signed(phase[31:0]));
            x = 652032874;
            y = 0;
            flip = 0;
            // fold into +-quarter turn
            if (z > 64'sd1073741824) begin
                z = z - 64'sd2147483648;
                flip = 1;
            end else if (z < -64'sd1073741824) begin
                z = z + 64'sd2147483648;
                flip = 1;
            end
            for (i = 0; i < STAGES; i++) begin
                dx = y >>> (i % 32);
                dy = x >>> (i % 32);
                atn = longint'({32'd0, ATAN_TURNS[i % 32]});
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - atn;
                end else begin
                    x = x + dx; y = y - dy; z = z + atn;
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            q[0] = x;
            for (i = 0; i < 3; i++) begin
                sg = ((om[i] < 0) != (y < 0)) ? -1 : 1;
                q[i + 1] = div_nearest(sg, abs64(om[i]) * abs64(y), mag);
            end
        end
        n2 = 0;
        for (i = 0; i < 4; i++) n2 = n2 + abs64(q[i]) * abs64(q[i]);
        n = root64(n2);
        for (i = 0; i < 4; i++) begin
            v = q[i];
            if (n > 0) v = div_nearest(q[i], abs64(q[i]) << 30, n);
            if (v > 64'sd1073741824) v = 64'sd1073741824;
            if (v < -64'sd1073741824) v = -64'sd1073741824;
            q[i] = v;
        end
        res.w = q[0][31:0];
        res.x = q[1][31:0];
        res.y = q[2][31:0];
        res.z = q[3][31:0];
        res.small_ang = is_small;
        return res;
    endfunction

    // ---------------- pacing ----------------
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    int stall_left = 0;
    always @(negedge clk) begin
        if (stall_left > 0) begin
            quat_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            quat_ch.ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // ---------------- check ----------------
    always @(posedge clk) begin
        t_quat_beat exp_q;
        if (rst_n && quat_ch.valid && quat_ch.ready) begin
            if (pending_quats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat w=%0d x=%0d y=%0d z=%0d",
                             quat_ch.q_w, quat_ch.q_x, quat_ch.q_y, quat_ch.q_z);
            end else begin
                exp_q = pending_quats.pop_front();
                if (quat_ch.q_w !== exp_q.w || quat_ch.q_x !== exp_q.x ||
                    quat_ch.q_y !== exp_q.y || quat_ch.q_z !== exp_q.z ||
                    quat_ch.small_angle !== exp_q.small_ang) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp w=%0d x=%0d y=%0d z=%0d s=%0b",
                                  " | got w=%0d x=%0d y=%0d z=%0d s=%0b"},
                                 exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.small_ang,
                                 quat_ch.q_w, quat_ch.q_x, quat_ch.q_y, quat_ch.q_z,
                                 quat_ch.small_angle);
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk) begin
        if ((rate_ch.valid && rate_ch.ready) || (quat_ch.valid && quat_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- drivers ----------------
    task automatic send_rate(input t_rate ox, input t_rate oy, input t_rate oz);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            rate_ch.valid <= 1'b0;
        end
        @(negedge clk);
        rate_ch.valid   <= 1'b1;
        rate_ch.omega_x <= ox;
        rate_ch.omega_y <= oy;
        rate_ch.omega_z <= oz;
        @(posedge clk);
        while (!rate_ch.ready) @(posedge clk);
        pending_quats.push_back(rate_to_quat(ox, oy, oz, cur_period));
    endtask

    task automatic drain();
        @(negedge clk);
        rate_ch.valid <= 1'b0;
        while (pending_quats.size() > 0) @(posedge clk);
        // let any beat still in flight settle
        repeat (PIPE_DEPTH + 20) @(posedge clk);
    endtask

    task automatic write_period(input t_period dt);
        drain();
        @(negedge clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.sample_period <= dt;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cur_period = dt;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_rate rand_rate();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return $urandom_range(0, 400) - 200;
        if (r < 6) return t_rate'($signed($urandom_range(0, 1 << 26))) - (1 << 25);
        return t_rate'($urandom());
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        send_rate(0, 0, 0);
        send_rate(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_rate(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_rate(32'sh80000000, 0, 32'sh7FFFFFFF);
        send_rate(1, -1, 1);
        send_rate(167, 0, 0);
        send_rate(168, 0, 0);
        send_rate(0, -169, 0);
        send_rate(1 << 24, 0, 0);
        send_rate(0, 0, -(1 << 24));
        send_rate(-1, -1, -1);
        send_rate(32'sh12345678, -32'sh0ABCDEF0, 32'sh01020304);
    endtask

    task automatic test_periods();
        t_period dts [5];
        dts = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd4294967, 32'h8000_0000};
        foreach (dts[k]) begin
            write_period(dts[k]);
            send_rate(0, 0, 0);
            send_rate(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
            send_rate(100, -100, 50);
            send_rate(1 << 24, 1 << 23, -(1 << 22));
        end
    endtask

    task automatic test_random(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            if (k % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            send_rate(rand_rate(), rand_rate(), rand_rate());
        end
        no_gaps = 0;
    endtask

    task automatic test_pause();
        int k;
        for (k = 0; k < 20; k++) send_rate(rand_rate(), rand_rate(), rand_rate());
        // hold the sender until the pipeline has emptied
        @(negedge clk);
        rate_ch.valid <= 1'b0;
        while (pending_quats.size() > 0) @(posedge clk);
        for (k = 0; k < 20; k++) send_rate(rand_rate(), rand_rate(), rand_rate());
    endtask

    initial begin
        no_gaps     = 0;
        cur_period  = PERIOD_RESET;
        rst_n                <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.sample_period <= '0;
        rate_ch.valid        <= 1'b0;
        rate_ch.omega_x      <= '0;
        rate_ch.omega_y      <= '0;
        rate_ch.omega_z      <= '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_periods();
        test_pause();
        write_period(PERIOD_RESET);
        test_random(500);
        write_period(32'd1);
        test_random(200);
        write_period(32'hFFFF_FFFF);
        test_random(300);
        write_period($urandom_range(1, 32'h00FF_FFFF));
        test_random(300);
        write_period($urandom());
        test_random(200);

        drain();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
